### hw/rtl/mpf_pkg.sv
// Shared types and constants for the multichannel PWM fader.
package mpf_pkg;

  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned CHAN_W = 2;
  localparam int unsigned DUTY_W = 8;
  localparam int unsigned PIN_W = 4;
  localparam logic [DUTY_W-1:0] FADE_MASK_RESET = 8'h80;
  localparam logic [DUTY_W-1:0] PHASE_STEP = 8'd2;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_SET  = 1'b1
  } kind_t;

  typedef struct packed {
    logic              tick;
    logic              set;
    logic [DUTY_W-1:0] duty;
  } lane_ctrl_t;

endpackage

### hw/rtl/mpf_lane.sv
// One PWM channel: duty ramp, phase and fade counters, active flag.
module mpf_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [mpf_pkg::DUTY_W-1:0] fade_mask,
  input  mpf_pkg::lane_ctrl_t       ctrl,
  output logic                      pin,
  output logic                      active_next
);
  import mpf_pkg::*;

  logic [DUTY_W-1:0] actual_duty, actual_duty_next;
  logic [DUTY_W-1:0] target_duty;
  logic [DUTY_W-1:0] phase_count;
  logic [DUTY_W-1:0] fade_count;
  logic              channel_active;
  logic              fade_hit;

  always_comb begin
    fade_hit         = (fade_count & fade_mask) != '0;
    actual_duty_next = actual_duty;
    active_next      = channel_active;
    if (fade_hit) begin
      if (actual_duty < target_duty) begin
        actual_duty_next = actual_duty + 1'b1;
      end else if (actual_duty > target_duty) begin
        actual_duty_next = actual_duty - 1'b1;
      end else if (target_duty == '0) begin
        active_next = 1'b0;
      end
    end
    pin = phase_count < actual_duty_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      actual_duty    <= '0;
      target_duty    <= '0;
      phase_count    <= '0;
      fade_count     <= '0;
      channel_active <= 1'b0;
    end else if (ctrl.set) begin
      target_duty <= ctrl.duty;
      if (ctrl.duty != '0) begin
        channel_active <= 1'b1;
      end
    end else if (ctrl.tick) begin
      actual_duty    <= actual_duty_next;
      channel_active <= active_next;
      phase_count    <= phase_count + PHASE_STEP;
      fade_count     <= fade_hit ? DUTY_W'(1) : fade_count + 1'b1;
    end
  end

endmodule

### hw/rtl/multichannel_pwm_fader.sv
// Top level of the multichannel PWM fader: request register, lanes, result register.
//
// Input channel (in_valid/in_stall): kind 0 is a timer tick, kind 1 writes
// duty_value as the target of one channel. A request is taken at an edge
// with in_valid high and in_stall low. Set-duty requests give no result,
// nor do ticks while the block is stopped. A tick while running gives one
// result: pin_levels (bit i = channel i) and still_running.
// Output channel (out_valid/out_stall): the result is held while out_stall
// is high; the input stalls only while a tick waits in the request register
// and the result register is full with out_stall high.
// A tick passes the request register, then the result register. Throughput:
// one request per cycle unless stalled; all channels update side by side in
// the single stage between the request register and the result register.
// Config (cfg_valid/cfg_ready): cfg_fade_mask, always ready, write only
// while idle.
// Reset (rst, synchronous): all channel state cleared, block stopped,
// fade mask 0x80, no result pending.
module multichannel_pwm_fader #(
  parameter int unsigned CHANNELS = mpf_pkg::CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       kind,
  input  logic [mpf_pkg::CHAN_W-1:0] channel,
  input  logic [mpf_pkg::DUTY_W-1:0] duty_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mpf_pkg::PIN_W-1:0]  pin_levels,
  output logic                       still_running,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mpf_pkg::DUTY_W-1:0] cfg_fade_mask
);
  import mpf_pkg::*;

  logic              req_valid;
  kind_t             req_kind;
  logic [CHAN_W-1:0] req_channel;
  logic [DUTY_W-1:0] req_duty;
  logic [DUTY_W-1:0] fade_mask;
  logic              running;
  logic              advance;
  logic              do_tick;
  logic [CHANNELS-1:0] pin_vec;
  logic [CHANNELS-1:0] active_vec;
  logic [PIN_W-1:0]  pins_next;

  assign cfg_ready = 1'b1;
  assign advance   = req_valid && (req_kind == KIND_SET || !out_valid || !out_stall);
  assign do_tick   = advance && req_kind == KIND_TICK && running;
  assign in_stall  = req_valid && !advance;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    lane_ctrl_t ctrl;
    always_comb begin
      ctrl.tick = do_tick;
      ctrl.duty = req_duty;
      ctrl.set  = 1'b0;
      if (i < (1 << CHAN_W)) begin
        ctrl.set = advance && req_kind == KIND_SET && req_channel == CHAN_W'(i);
      end
    end
    mpf_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .fade_mask   (fade_mask),
      .ctrl        (ctrl),
      .pin         (pin_vec[i]),
      .active_next (active_vec[i])
    );
  end

  for (genvar b = 0; b < PIN_W; b++) begin : g_pin
    if (b < CHANNELS) begin : g_on
      assign pins_next[b] = pin_vec[b];
    end else begin : g_off
      assign pins_next[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
      running   <= 1'b0;
      fade_mask <= FADE_MASK_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fade_mask <= cfg_fade_mask;
      end
      if (!in_stall) begin
        req_valid <= in_valid;
      end
      if (do_tick) begin
        out_valid <= 1'b1;
        running   <= |active_vec;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (advance && req_kind == KIND_SET && req_duty != '0 &&
          32'(req_channel) < CHANNELS) begin
        running <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_kind    <= kind_t'(kind);
      req_channel <= channel;
      req_duty    <= duty_value;
    end
    if (do_tick) begin
      pin_levels    <= pins_next;
      still_running <= |active_vec;
    end
  end

endmodule

### hw/rtl/mpf_checker.sv
// Port-level assertions for the multichannel PWM fader, bound to the top level.
module mpf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [mpf_pkg::PIN_W-1:0]  pin_levels,
  input logic                       still_running
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pin_levels) && $stable(still_running))
    else $error("stalled result changed");

endmodule

bind multichannel_pwm_fader mpf_checker u_mpf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .pin_levels    (pin_levels),
  .still_running (still_running)
);
